### rtl/tssa_pkg.sv
// tssa_pkg: shared constants for the two-stacks-in-one-store core.
// Holds opcode and status codes, field widths and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package tssa_pkg;

  // Parameter defaults
  localparam int unsigned DepthDef = 16;
  localparam int unsigned WidthDef = 32;

  // Field widths of the item and result ports
  localparam int unsigned OpW   = 3;
  localparam int unsigned ValW  = 32;
  localparam int unsigned SizeW = 5;
  localparam int unsigned StatW = 2;

  // Opcodes; any other value acts as report only
  localparam logic [OpW-1:0] OP_PUSH_FIRST  = 3'd0;
  localparam logic [OpW-1:0] OP_PUSH_SECOND = 3'd1;
  localparam logic [OpW-1:0] OP_POP_FIRST   = 3'd2;
  localparam logic [OpW-1:0] OP_POP_SECOND  = 3'd3;
  localparam logic [OpW-1:0] OP_REPORT      = 3'd4;

  // Status codes
  localparam logic [StatW-1:0] ST_DONE   = 2'd0;
  localparam logic [StatW-1:0] ST_FULL   = 2'd1;
  localparam logic [StatW-1:0] ST_EMPTY  = 2'd2;
  localparam logic [StatW-1:0] ST_UNUSED = 2'd3;

endpackage

### rtl/tssa_ram.sv
// tssa_ram: single-write, single-read synchronous store with registered read data.
// Holds the entries of both stacks. Depends on nothing.
`timescale 1ns / 1ps

module tssa_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned DW    = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/two_stacks_shared_array_core.sv
// two_stacks_shared_array_core: two LIFO stacks in one store, first grows up, second down.
// Depends on tssa_pkg and tssa_ram.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+--------------------------
//   item    | opcode_i, push_value_i                  | start high, busy low
//   result  | first_top_o, second_top_o, first_size_o,| done_o strobe, one cycle
//           | second_size_o, status_o                 |
//
// For a push, a refused push, an empty pop, a pop that empties its stack and a report,
// done_o rises the cycle after the item is taken and busy stays low.
// A pop that leaves its stack non-empty goes through S_READ: the new top comes from one
// read of the registered store port; busy is high in S_READ and done_o rises the cycle after.
// Reset empties both stacks; the store itself is not cleared, only written entries are read.
// The receiver cannot stall: done_o marks each result for exactly one cycle.
`timescale 1ns / 1ps

module two_stacks_shared_array_core #(
  parameter int unsigned DEPTH = tssa_pkg::DepthDef,
  parameter int unsigned WIDTH = tssa_pkg::WidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [tssa_pkg::OpW-1:0]     opcode_i,
  input  logic [tssa_pkg::ValW-1:0]    push_value_i,
  output logic                         done_o,
  output logic [tssa_pkg::ValW-1:0]    first_top_o,
  output logic [tssa_pkg::ValW-1:0]    second_top_o,
  output logic [tssa_pkg::SizeW-1:0]   first_size_o,
  output logic [tssa_pkg::SizeW-1:0]   second_size_o,
  output logic [tssa_pkg::StatW-1:0]   status_o
);

  localparam int unsigned DW = (WIDTH < tssa_pkg::ValW) ? WIDTH : tssa_pkg::ValW;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e                      state_q, state_d;
  logic [CW-1:0]               cnt1_q, cnt1_d, cnt2_q, cnt2_d;
  logic [DW-1:0]               top1_q, top1_d, top2_q, top2_d;
  logic                        sel2_q, sel2_d;
  logic                        done_q, done_d;
  logic [tssa_pkg::StatW-1:0]  stat_q, stat_d;

  logic                        accept;
  logic                        full;
  logic [CW:0]                 total;
  logic [DW-1:0]               val;
  logic                        we, re;
  logic [AW-1:0]               waddr, raddr;
  logic [DW-1:0]               rdata;

  assign accept = start && (state_q == S_IDLE);
  assign total  = {1'b0, cnt1_q} + {1'b0, cnt2_q};
  assign full   = (total >= (CW + 1)'(DEPTH));
  assign val    = push_value_i[DW-1:0];

  // Decode the item, move at most one pointer, pick the store access
  always_comb begin
    state_d = state_q;
    cnt1_d  = cnt1_q;
    cnt2_d  = cnt2_q;
    top1_d  = top1_q;
    top2_d  = top2_q;
    sel2_d  = sel2_q;
    done_d  = 1'b0;
    stat_d  = stat_q;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = cnt1_q[AW-1:0];
    raddr   = AW'(cnt1_q - CW'(2));
    case (state_q)
      S_IDLE: begin
        if (start) begin
          stat_d = tssa_pkg::ST_DONE;
          done_d = 1'b1;
          case (opcode_i)
            tssa_pkg::OP_PUSH_FIRST: begin
              if (full) begin
                stat_d = tssa_pkg::ST_FULL;
              end else begin
                we     = 1'b1;
                waddr  = cnt1_q[AW-1:0];
                cnt1_d = cnt1_q + CW'(1);
                top1_d = val;
              end
            end
            tssa_pkg::OP_PUSH_SECOND: begin
              if (full) begin
                stat_d = tssa_pkg::ST_FULL;
              end else begin
                we     = 1'b1;
                waddr  = AW'(CW'(DEPTH - 1) - cnt2_q);
                cnt2_d = cnt2_q + CW'(1);
                top2_d = val;
              end
            end
            tssa_pkg::OP_POP_FIRST: begin
              if (cnt1_q == '0) begin
                stat_d = tssa_pkg::ST_EMPTY;
              end else begin
                cnt1_d = cnt1_q - CW'(1);
                if (cnt1_q == CW'(1)) begin
                  top1_d = '0;
                end else begin
                  // fetch the entry below the old top
                  re      = 1'b1;
                  raddr   = AW'(cnt1_q - CW'(2));
                  sel2_d  = 1'b0;
                  done_d  = 1'b0;
                  state_d = S_READ;
                end
              end
            end
            tssa_pkg::OP_POP_SECOND: begin
              if (cnt2_q == '0) begin
                stat_d = tssa_pkg::ST_EMPTY;
              end else begin
                cnt2_d = cnt2_q - CW'(1);
                if (cnt2_q == CW'(1)) begin
                  top2_d = '0;
                end else begin
                  re      = 1'b1;
                  raddr   = AW'((CW'(DEPTH) - cnt2_q) + CW'(1));
                  sel2_d  = 1'b1;
                  done_d  = 1'b0;
                  state_d = S_READ;
                end
              end
            end
            default: begin
              // report only, unused codes too
            end
          endcase
        end
      end
      S_READ: begin
        if (sel2_q) begin
          top2_d = rdata;
        end else begin
          top1_d = rdata;
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state, counts, cached tops and the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt1_q  <= '0;
      cnt2_q  <= '0;
      top1_q  <= '0;
      top2_q  <= '0;
      sel2_q  <= 1'b0;
      done_q  <= 1'b0;
      stat_q  <= tssa_pkg::ST_DONE;
    end else begin
      state_q <= state_d;
      cnt1_q  <= cnt1_d;
      cnt2_q  <= cnt2_d;
      top1_q  <= top1_d;
      top2_q  <= top2_d;
      sel2_q  <= sel2_d;
      done_q  <= done_d;
      stat_q  <= stat_d;
    end
  end

  tssa_ram #(
    .DEPTH (DEPTH),
    .DW    (DW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we && accept),
    .waddr_i (waddr),
    .wdata_i (val),
    .re_i    (re && accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign busy          = (state_q == S_READ);
  assign done_o        = done_q;
  assign first_top_o   = tssa_pkg::ValW'(top1_q);
  assign second_top_o  = tssa_pkg::ValW'(top2_q);
  assign first_size_o  = tssa_pkg::SizeW'(cnt1_q);
  assign second_size_o = tssa_pkg::SizeW'(cnt2_q);
  assign status_o      = stat_q;

endmodule

### rtl/tssa_checker.sv
// tssa_checker: port-level checks on the two-stacks core, bound to the top level.
// Depends on tssa_pkg and two_stacks_shared_array_core.
`timescale 1ns / 1ps

module tssa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [tssa_pkg::OpW-1:0]    opcode_i,
  input logic                        done_o,
  input logic [tssa_pkg::SizeW-1:0]  first_size_o,
  input logic [tssa_pkg::SizeW-1:0]  second_size_o,
  input logic [tssa_pkg::StatW-1:0]  status_o
);

  // A result follows an accepted item or the read wait
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start && !busy) || $past(busy)))
    else $error("result strobe without a taken item");

  // The read wait is followed directly by a result, with busy low again
  a_busy_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (!busy && done_o))
    else $error("busy longer than one cycle");

  // Busy only right after an item is taken
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> $past(start && !busy))
    else $error("busy without a taken item");

  // A report leaves both sizes alone and reports done
  a_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i >= tssa_pkg::OP_REPORT) |=>
      (done_o && status_o == tssa_pkg::ST_DONE &&
       $stable(first_size_o) && $stable(second_size_o)))
    else $error("report changed state");

  // The unused status code never shows
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o != tssa_pkg::ST_UNUSED))
    else $error("bad status code");

endmodule

bind two_stacks_shared_array_core tssa_checker u_tssa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .opcode_i      (opcode_i),
  .done_o        (done_o),
  .first_size_o  (first_size_o),
  .second_size_o (second_size_o),
  .status_o      (status_o)
);

### bench/tb_two_stacks_shared_array_core.sv
// tb_two_stacks_shared_array_core: self-checking bench for the two-stacks-in-one-store core.
// Mirrors both stacks and the shared store and checks every result strobe field by field.
// Depends on tssa_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_two_stacks_shared_array_core;
  import tssa_pkg::*;

  localparam int Depth      = DepthDef;
  localparam int CycleLimit = 100000;

  typedef struct packed {
    logic [ValW-1:0]  first_top;
    logic [ValW-1:0]  second_top;
    logic [SizeW-1:0] first_size;
    logic [SizeW-1:0] second_size;
    logic [StatW-1:0] status;
  } stack_view_t;

  typedef enum {
    MIX_BALANCED,
    MIX_GROW,
    MIX_SHRINK,
    MIX_FIRST,
    MIX_SECOND
  } op_mix_e;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [OpW-1:0]   opcode_i;
  logic [ValW-1:0]  push_value_i;
  logic             done_o;
  logic [ValW-1:0]  first_top_o;
  logic [ValW-1:0]  second_top_o;
  logic [SizeW-1:0] first_size_o;
  logic [SizeW-1:0] second_size_o;
  logic [StatW-1:0] status_o;

  // Mirror of the block state
  logic [ValW-1:0] stack_store [Depth];
  int              first_cnt;
  int              second_cnt;

  stack_view_t     pending_views[$];
  bit              idle_on;
  int              error_count;
  int              items_sent;
  int              results_seen;
  int              full_refusals;
  int              empty_pops;
  int              peak_first;
  int              peak_second;
  int              cycle_count;

  two_stacks_shared_array_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .push_value_i  (push_value_i),
    .done_o        (done_o),
    .first_top_o   (first_top_o),
    .second_top_o  (second_top_o),
    .first_size_o  (first_size_o),
    .second_size_o (second_size_o),
    .status_o      (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results pending", cycle_count,
               pending_views.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Apply one operation to the mirror and return the view the block should report
  function automatic stack_view_t apply_stack_op(input logic [OpW-1:0] op,
                                                 input logic [ValW-1:0] val);
    stack_view_t v;
    bit          full;
    full     = (first_cnt + second_cnt) >= Depth;
    v.status = ST_DONE;
    case (op)
      OP_PUSH_FIRST: begin
        if (full) begin
          v.status = ST_FULL;
        end else begin
          stack_store[first_cnt] = val;
          first_cnt++;
        end
      end
      OP_PUSH_SECOND: begin
        if (full) begin
          v.status = ST_FULL;
        end else begin
          stack_store[Depth - 1 - second_cnt] = val;
          second_cnt++;
        end
      end
      OP_POP_FIRST: begin
        if (first_cnt == 0) v.status = ST_EMPTY;
        else first_cnt--;
      end
      OP_POP_SECOND: begin
        if (second_cnt == 0) v.status = ST_EMPTY;
        else second_cnt--;
      end
      default: ;
    endcase
    v.first_top   = (first_cnt == 0) ? '0 : stack_store[first_cnt - 1];
    v.second_top  = (second_cnt == 0) ? '0 : stack_store[Depth - second_cnt];
    v.first_size  = SizeW'(first_cnt);
    v.second_size = SizeW'(second_cnt);
    if (v.status == ST_FULL) full_refusals++;
    if (v.status == ST_EMPTY) empty_pops++;
    if (first_cnt > peak_first) peak_first = first_cnt;
    if (second_cnt > peak_second) peak_second = second_cnt;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [ValW-1:0] want,
                                 input logic [ValW-1:0] got);
    error_count++;
    if (error_count <= 40)
      $display("ERROR result %0d %s: expected %h, got %h", results_seen, what, want, got);
  endtask

  // Send one item: maybe idle first, then hold start until the block takes it
  task automatic send_item(input logic [OpW-1:0] op, input logic [ValW-1:0] val);
    if (idle_on && $urandom_range(0, 99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    start        <= 1'b1;
    opcode_i     <= op;
    push_value_i <= val;
    do @(posedge clk_i); while (busy);
    pending_views.push_back(apply_stack_op(op, val));
    items_sent++;
  endtask

  // Drop start and hold off until every expected result has come
  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ValW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1:       return '1;
      2:       return ValW'(1) << $urandom_range(0, ValW - 1);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OpW-1:0] pick_opcode(input op_mix_e mix);
    int r;
    int push_a;
    int push_b;
    int pop_a;
    int pop_b;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:   begin push_a = 40; push_b = 80; pop_a = 90; pop_b = 95; end
      MIX_SHRINK: begin push_a = 8;  push_b = 16; pop_a = 56; pop_b = 95; end
      MIX_FIRST:  begin push_a = 45; push_b = 50; pop_a = 85; pop_b = 90; end
      MIX_SECOND: begin push_a = 5;  push_b = 50; pop_a = 55; pop_b = 90; end
      default:    begin push_a = 25; push_b = 50; pop_a = 70; pop_b = 90; end
    endcase
    if (r < push_a) return OP_PUSH_FIRST;
    if (r < push_b) return OP_PUSH_SECOND;
    if (r < pop_a) return OP_POP_FIRST;
    if (r < pop_b) return OP_POP_SECOND;
    return OpW'($urandom_range(int'(OP_REPORT), 2**OpW - 1));
  endfunction

  // Empty stacks, extreme values, every opcode including the spare ones
  task automatic test_basic_ops();
    send_item(OP_REPORT, '1);
    send_item(OP_POP_FIRST, '0);
    send_item(OP_POP_SECOND, '1);
    send_item(OP_PUSH_FIRST, '0);
    send_item(OP_PUSH_SECOND, '1);
    send_item(OP_PUSH_FIRST, '1);
    send_item(OP_PUSH_SECOND, '0);
    for (int k = int'(OP_REPORT) + 1; k < 2**OpW; k++) send_item(OpW'(k), $urandom);
    // Pops that leave the stack non-empty, then pops that empty it
    send_item(OP_POP_FIRST, $urandom);
    send_item(OP_POP_SECOND, $urandom);
    send_item(OP_POP_FIRST, $urandom);
    send_item(OP_POP_SECOND, $urandom);
  endtask

  // Fill the store from both ends until the stacks meet, push into it, then free one entry and refill it
  task automatic test_full_store();
    for (int k = 0; k < Depth - 6; k++) send_item(OP_PUSH_FIRST, $urandom);
    for (int k = 0; k < 6; k++) send_item(OP_PUSH_SECOND, $urandom);
    send_item(OP_PUSH_FIRST, '1);
    send_item(OP_PUSH_SECOND, '1);
    send_item(OP_POP_FIRST, '0);
    send_item(OP_PUSH_SECOND, $urandom);
    wait_for_results();
  endtask

  // Random traffic in bursts of one mix; the first stretch runs without idling
  task automatic test_random_traffic(input int n_items);
    op_mix_e mix;
    mix     = MIX_BALANCED;
    idle_on = 1'b0;
    for (int i = 0; i < n_items; i++) begin
      if (i == 200) idle_on = 1'b1;
      if (i % 40 == 0) mix = op_mix_e'($urandom_range(0, 4));
      if (i % 150 == 149) wait_for_results();
      send_item(pick_opcode(mix), pick_value());
    end
  endtask

  // Compare each result strobe with the oldest expectation
  always @(posedge clk_i) begin
    stack_view_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_views.size() == 0) begin
        report_mismatch("strobe with nothing pending", '0, '0);
      end else begin
        want = pending_views.pop_front();
        if (first_top_o !== want.first_top)
          report_mismatch("first_top", want.first_top, first_top_o);
        if (second_top_o !== want.second_top)
          report_mismatch("second_top", want.second_top, second_top_o);
        if (first_size_o !== want.first_size)
          report_mismatch("first_size", ValW'(want.first_size), ValW'(first_size_o));
        if (second_size_o !== want.second_size)
          report_mismatch("second_size", ValW'(want.second_size), ValW'(second_size_o));
        if (status_o !== want.status)
          report_mismatch("status", ValW'(want.status), ValW'(status_o));
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    opcode_i     = OP_REPORT;
    push_value_i = '0;
    first_cnt    = 0;
    second_cnt   = 0;
    idle_on      = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_basic_ops();
    test_full_store();
    test_random_traffic(1200);

    // Drain and let the last strobe settle
    wait_for_results();
    repeat (4) @(posedge clk_i);
    if (pending_views.size() != 0)
      report_mismatch("results never arrived", ValW'(pending_views.size()), '0);

    $display("Sent %0d items, checked %0d results: %0d refused pushes, %0d empty pops",
             items_sent, results_seen, full_refusals, empty_pops);
    $display("Peak stack sizes: first %0d, second %0d of %0d entries",
             peak_first, peak_second, Depth);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
